// ----- sv/lzwbsc_pkg.sv -----
// lzwbsc_pkg: shared constants and types of the lzw byte stream compressor
`timescale 1ns / 1ps
package lzwbsc_pkg;

    // default and limits of the code width
    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int START_WIDTH       = 9;

    // reserved codes
    localparam int CODE_CLEAR = 256;
    localparam int CODE_END   = 257;
    localparam int FIRST_FREE = 258;

    // bit packer sizes, enough for any code width up to twelve bits
    localparam int ACC_W  = 24;
    localparam int CNT_W  = 5;
    localparam int WID_W  = 4;
    localparam int BYTE_W = 8;

    // flags that travel with the last byte of a code push
    typedef struct packed {
        logic run_end;
        logic stream_end;
    } lzwbsc_mark_t;

endpackage

// ----- sv/lzw_byte_stream_compressor.sv -----
// lzw_byte_stream_compressor: variable width lzw encoder with msb-first byte packing
`timescale 1ns / 1ps
// One byte per input transaction goes in, packed LZW code bytes come out (clear code 256,
// end code 257, 9 to MAX_CODE_BITS bit codes). The dictionary lives in two synchronous
// memories: a child table indexed by {prefix, byte} and a key table indexed by code that
// holds the key each code was made for. A child entry counts only when its code lies in
// [258, next free code) and the key table confirms the key, so no clearing pass is needed,
// neither after reset nor when the dictionary is cleared. A byte that extends the prefix
// goes through a child read and a key read, with the compare overlapping the next child
// read; a byte that adds an entry does those reads and the compare, then pushes each code
// it emits, each waiting until the bit packer holds fewer than 8 bits. The packer hands
// out one byte per cycle while the output is accepted. A one-entry input register and the
// output register let a new transaction be taken while earlier results still wait.
module lzw_byte_stream_compressor
    import lzwbsc_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic              s_final_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_packed_byte,
    output logic              m_run_end,
    output logic              m_stream_end
);

    localparam int CODE_W    = MAX_CODE_BITS;
    localparam int IDX_W     = CODE_W + BYTE_W;
    localparam int NFC_W     = CODE_W + 1;
    localparam int TBL_DEPTH = 2 ** IDX_W;
    localparam int KEY_DEPTH = 2 ** CODE_W;

    localparam logic [CODE_W-1:0] CLR_CODE  = CODE_W'(CODE_CLEAR);
    localparam logic [CODE_W-1:0] END_CODE  = CODE_W'(CODE_END);
    localparam logic [CODE_W-1:0] FREE_CODE = CODE_W'(FIRST_FREE);
    localparam logic [NFC_W-1:0]  NFC_RESET = NFC_W'(FIRST_FREE);
    localparam logic [WID_W-1:0]  WID_START = WID_W'(START_WIDTH);
    localparam logic [WID_W-1:0]  WID_TOP   = WID_W'(MAX_CODE_BITS);
    localparam logic [CNT_W-1:0]  CNT_BYTE  = CNT_W'(BYTE_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_KEY,
        ST_CHECK,
        ST_CLR_FIRST,
        ST_MISS,
        ST_CLR_FULL,
        ST_FIN_PREFIX,
        ST_FIN_END
    } state_t;

    // dictionary memories, any power-up content is tolerated
    bit   [CODE_W-1:0] child_mem [TBL_DEPTH];
    bit   [IDX_W-1:0]  key_mem   [KEY_DEPTH];

    state_t            state_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_final_reg;
    logic [BYTE_W-1:0] cur_byte_reg;
    logic              cur_final_reg;
    logic [CODE_W-1:0] prefix_reg;
    logic [NFC_W-1:0]  nfc_reg;
    logic [WID_W-1:0]  width_reg;
    logic              first_reg;
    logic [CODE_W-1:0] child_rd_reg;
    logic [IDX_W-1:0]  key_rd_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [CNT_W-1:0]  cnt_reg;
    lzwbsc_mark_t      mark_reg;
    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_byte_reg;
    logic              m_run_end_reg;
    logic              m_stream_end_reg;

    logic [IDX_W-1:0]  cur_idx;
    logic              hit;
    logic              take;
    logic [CODE_W-1:0] rd_prefix;
    logic [IDX_W-1:0]  rd_addr;
    logic              child_rd_en;
    logic              miss_wr;
    logic [NFC_W-1:0]  nfc_inc;
    logic              at_top;
    logic              width_max;
    logic              grow_full;

    logic              pk_free;
    logic              emit;
    logic              push_en;
    logic [CODE_W-1:0] push_code;
    logic              push_pad;
    lzwbsc_mark_t      push_mark;
    logic [CNT_W-1:0]  sum_bits;
    logic [2:0]        pad_bits;
    logic [CNT_W-1:0]  shamt;
    logic [ACC_W-1:0]  code_ext;
    logic [ACC_W-1:0]  acc_push;
    logic [CNT_W-1:0]  cnt_push;
    logic [CNT_W-1:0]  cnt_emit;
    logic [BYTE_W-1:0] byte_emit;
    logic              last_of_push;

    // lookup control
    assign cur_idx = {prefix_reg, cur_byte_reg};
    assign hit     = (child_rd_reg >= FREE_CODE)
                     && ({1'b0, child_rd_reg} < nfc_reg)
                     && (key_rd_reg == cur_idx);
    assign take    = in_valid_reg
                     && ((state_reg == ST_IDLE)
                         || ((state_reg == ST_CHECK) && hit && !cur_final_reg));
    assign rd_prefix   = (state_reg == ST_CHECK) ? child_rd_reg : prefix_reg;
    assign rd_addr     = {rd_prefix, in_byte_reg};
    assign child_rd_en = take && !first_reg;
    assign miss_wr     = (state_reg == ST_CHECK) && !hit;
    assign s_ready     = !in_valid_reg || take;

    // width growth and dictionary full
    assign nfc_inc   = nfc_reg + NFC_W'(1);
    assign at_top    = nfc_inc >= (NFC_W'(1) << width_reg);
    assign width_max = (width_reg == WID_TOP);
    assign grow_full = at_top && width_max;

    // code push selection
    assign pk_free = cnt_reg < CNT_BYTE;
    always_comb begin
        push_en   = 1'b0;
        push_code = prefix_reg;
        push_pad  = 1'b0;
        push_mark = '0;
        case (state_reg)
            ST_CLR_FIRST: begin
                push_en           = pk_free;
                push_code         = CLR_CODE;
                push_mark.run_end = !cur_final_reg;
            end
            ST_MISS: begin
                push_en           = pk_free;
                push_mark.run_end = !cur_final_reg && !grow_full;
            end
            ST_CLR_FULL: begin
                push_en           = pk_free;
                push_code         = CLR_CODE;
                push_mark.run_end = !cur_final_reg;
            end
            ST_FIN_PREFIX: begin
                push_en = pk_free;
            end
            ST_FIN_END: begin
                push_en              = pk_free;
                push_code            = END_CODE;
                push_pad             = 1'b1;
                push_mark.run_end    = 1'b1;
                push_mark.stream_end = 1'b1;
            end
            default: begin
                push_en = 1'b0;
            end
        endcase
    end

    // bit packer arithmetic, end code padded up to a byte boundary
    assign sum_bits  = cnt_reg + CNT_W'(width_reg);
    assign pad_bits  = push_pad ? (3'd0 - sum_bits[2:0]) : 3'd0;
    assign shamt     = CNT_W'(width_reg) + CNT_W'(pad_bits);
    assign code_ext  = ACC_W'(push_code) & ~({ACC_W{1'b1}} << width_reg);
    assign acc_push  = (acc_reg << shamt) | (code_ext << pad_bits);
    assign cnt_push  = sum_bits + CNT_W'(pad_bits);
    assign cnt_emit  = cnt_reg - CNT_BYTE;
    assign byte_emit = BYTE_W'(acc_reg >> cnt_emit);
    assign last_of_push = cnt_emit < CNT_BYTE;
    assign emit      = !pk_free && (!m_valid_reg || m_ready);

    // child table: read for lookup, write on a new entry
    always_ff @(posedge aclk) begin
        if (child_rd_en) begin
            child_rd_reg <= child_mem[rd_addr];
        end
        if (miss_wr) begin
            child_mem[cur_idx] <= nfc_reg[CODE_W-1:0];
        end
    end

    // key table: confirms that a child code belongs to this key
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD_KEY) begin
            key_rd_reg <= key_mem[child_rd_reg];
        end
        if (miss_wr) begin
            key_mem[nfc_reg[CODE_W-1:0]] <= cur_idx;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                in_valid_reg <= 1'b0;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end
        end
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_final_reg <= s_final_byte;
        end
        if (take) begin
            cur_byte_reg  <= in_byte_reg;
            cur_final_reg <= in_final_reg;
        end
    end

    // encoder state machine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            prefix_reg <= '0;
            nfc_reg    <= NFC_RESET;
            width_reg  <= WID_START;
            first_reg  <= 1'b1;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        state_reg <= first_reg ? ST_CLR_FIRST : ST_RD_KEY;
                    end
                end
                ST_RD_KEY: begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (hit) begin
                        prefix_reg <= child_rd_reg;
                        if (cur_final_reg) begin
                            state_reg <= ST_FIN_PREFIX;
                        end else if (take) begin
                            state_reg <= ST_RD_KEY;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        state_reg <= ST_MISS;
                    end
                end
                ST_CLR_FIRST: begin
                    if (push_en) begin
                        prefix_reg <= CODE_W'(cur_byte_reg);
                        first_reg  <= 1'b0;
                        state_reg  <= cur_final_reg ? ST_FIN_PREFIX : ST_IDLE;
                    end
                end
                ST_MISS: begin
                    if (push_en) begin
                        nfc_reg    <= nfc_inc;
                        prefix_reg <= CODE_W'(cur_byte_reg);
                        if (at_top && !width_max) begin
                            width_reg <= width_reg + WID_W'(1);
                        end
                        if (grow_full) begin
                            state_reg <= ST_CLR_FULL;
                        end else begin
                            state_reg <= cur_final_reg ? ST_FIN_PREFIX : ST_IDLE;
                        end
                    end
                end
                ST_CLR_FULL: begin
                    if (push_en) begin
                        nfc_reg   <= NFC_RESET;
                        width_reg <= WID_START;
                        state_reg <= cur_final_reg ? ST_FIN_PREFIX : ST_IDLE;
                    end
                end
                ST_FIN_PREFIX: begin
                    if (push_en) begin
                        state_reg <= ST_FIN_END;
                    end
                end
                ST_FIN_END: begin
                    if (push_en) begin
                        nfc_reg    <= NFC_RESET;
                        width_reg  <= WID_START;
                        prefix_reg <= '0;
                        first_reg  <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // bit packer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            mark_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (push_en) begin
                cnt_reg  <= cnt_push;
                mark_reg <= push_mark;
            end else if (emit) begin
                cnt_reg <= cnt_emit;
                if (last_of_push) begin
                    mark_reg <= '0;
                end
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (push_en) begin
            acc_reg <= acc_push;
        end
        if (emit) begin
            m_byte_reg       <= byte_emit;
            m_run_end_reg    <= last_of_push && mark_reg.run_end;
            m_stream_end_reg <= last_of_push && mark_reg.stream_end;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_packed_byte = m_byte_reg;
    assign m_run_end     = m_run_end_reg;
    assign m_stream_end  = m_stream_end_reg;

endmodule

// ----- tb/tb.sv -----
// tb: self-checking testbench for the lzw byte stream compressor
`timescale 1ns / 1ps
module tb;
    import lzwbsc_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 20;

    // one packed output byte with its markers
    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              run_end;
        logic              stream_end;
    } packed_result_t;

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_data_byte  = '0;
    logic              s_final_byte = 1'b0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [BYTE_W-1:0] m_packed_byte;
    logic              m_run_end;
    logic              m_stream_end;

    lzw_byte_stream_compressor u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_final_byte  (s_final_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packed_byte (m_packed_byte),
        .m_run_end     (m_run_end),
        .m_stream_end  (m_stream_end)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // encoder state mirrored by the testbench
    bit [11:0]      child_code [int];
    int unsigned    cur_prefix;
    int unsigned    free_code;
    int unsigned    width;
    bit [ACC_W-1:0] bit_acc;
    int unsigned    acc_bits;
    bit             stream_open;

    packed_result_t code_bytes_q [$];
    packed_result_t expected_bytes [$];

    // run bookkeeping
    int  error_count   = 0;
    int  bytes_sent    = 0;
    int  bytes_checked = 0;
    int  streams_done  = 0;
    int  full_clears   = 0;
    int  peak_width    = START_WIDTH;
    int  stall_cycles  = 0;
    bit  tx_idle_on    = 1'b0;
    bit  rx_idle_on    = 1'b0;
    int  rx_hold_req   = 0;

    // most gaps short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void clear_dictionary();
        child_code.delete();
        free_code = FIRST_FREE;
        width     = START_WIDTH;
    endfunction

    function automatic void restart_encoder();
        clear_dictionary();
        cur_prefix  = 0;
        bit_acc     = '0;
        acc_bits    = 0;
        stream_open = 1'b0;
    endfunction

    // append one code msb first and collect every completed byte
    function automatic void pack_code(input int unsigned code);
        packed_result_t r;
        bit_acc  = ACC_W'((bit_acc << width) | (code & ((1 << width) - 1)));
        acc_bits = acc_bits + width;
        while (acc_bits >= 8) begin
            acc_bits      = acc_bits - 8;
            r.packed_byte = 8'(bit_acc >> acc_bits);
            r.run_end     = 1'b0;
            r.stream_end  = 1'b0;
            code_bytes_q.insert(code_bytes_q.size(), r);
            bit_acc = bit_acc & ((24'd1 << acc_bits) - 24'd1);
        end
    endfunction

    // work out the packed bytes caused by one input transaction
    function automatic void predict_lzw_bytes(input logic [7:0] d, input logic fin);
        packed_result_t r;
        int             key;
        code_bytes_q.delete();
        if (!stream_open) begin
            stream_open = 1'b1;
            cur_prefix  = 32'(d);
            pack_code(CODE_CLEAR);
        end else begin
            key = int'((cur_prefix << 8) | d);
            if (child_code.exists(key)) begin
                cur_prefix = 32'(child_code[key]);
            end else begin
                pack_code(cur_prefix);
                child_code[key] = free_code[11:0];
                free_code = free_code + 1;
                // width grows, or the dictionary starts over at the top width
                if (free_code >= (1 << width)) begin
                    if (width < MAX_CODE_BITS_DEF) begin
                        width = width + 1;
                        if (width > peak_width) peak_width = width;
                    end else begin
                        pack_code(CODE_CLEAR);
                        clear_dictionary();
                        full_clears++;
                    end
                end
                cur_prefix = 32'(d);
            end
        end
        // flush with the prefix, the end code and zero padding
        if (fin) begin
            pack_code(cur_prefix);
            pack_code(CODE_END);
            if (acc_bits > 0) begin
                r.packed_byte = 8'(bit_acc << (8 - acc_bits));
                r.run_end     = 1'b0;
                r.stream_end  = 1'b0;
                code_bytes_q.insert(code_bytes_q.size(), r);
            end
            r = code_bytes_q.pop_back();
            r.stream_end = 1'b1;
            code_bytes_q.insert(code_bytes_q.size(), r);
            restart_encoder();
            streams_done++;
        end
        if (code_bytes_q.size() > 0) begin
            r = code_bytes_q.pop_back();
            r.run_end = 1'b1;
            code_bytes_q.insert(code_bytes_q.size(), r);
        end
        foreach (code_bytes_q[i]) expected_bytes.insert(expected_bytes.size(), code_bytes_q[i]);
    endfunction

    // offer one byte and wait for its transaction
    task automatic send_byte(input logic [7:0] d, input logic fin);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= d;
        s_final_byte <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_lzw_bytes(d, fin);
        bytes_sent++;
    endtask

    // stop offering and wait for every expected byte
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_bytes.size() != 0) @(posedge aclk);
    endtask

    // stream of random bytes from a window of the given size, final on the last
    task automatic send_stream(input int len, input int alphabet);
        logic [7:0] base;
        base = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++) begin
            send_byte(base + 8'($urandom_range(0, alphabet - 1)), i == len - 1);
        end
    endtask

    // single byte streams at both byte extremes, the second offered right after the first is taken
    task automatic test_single_byte_streams();
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        drain_results();
    endtask

    // six distinct bytes give eight nine-bit codes, so no padding byte
    task automatic test_aligned_end();
        for (int i = 0; i < 6; i++) send_byte(8'(i), i == 5);
        drain_results();
    endtask

    // repeated pairs extend the prefix, so some bytes produce no output
    task automatic test_prefix_extension();
        logic [7:0] pattern [10];
        pattern = '{8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42, 8'hff, 8'hff, 8'hff, 8'h80};
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (pattern[i]) send_byte(pattern[i], i == 9);
        drain_results();
    endtask

    // random streams, one long enough to grow the code width
    task automatic test_random_streams();
        int target;
        target = bytes_sent + 266;
        tx_idle_on = 1'b1;
        send_stream(262, 256);
        while (bytes_sent < target) begin
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 1) == 0) send_stream($urandom_range(1, 20), 256);
            else send_stream($urandom_range(1, 20), $urandom_range(1, 4));
        end
        drain_results();
    endtask

    // receiver holds off while the sender keeps offering bytes
    task automatic test_backpressure();
        tx_idle_on  = 1'b0;
        rx_hold_req = 400;
        send_stream(16, 256);
        drain_results();
    endtask

    // sender pauses mid stream until everything is out, then carries on
    task automatic test_sender_pause();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
        drain_results();
        for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(0, 255)), i == 5);
        drain_results();
    endtask

    // receiver: random stalls plus a long hold-off when asked
    int hold_left = 0;
    int rx_gap    = 0;
    always @(posedge aclk) begin
        if (rx_hold_req > 0) begin
            hold_left   = rx_hold_req;
            rx_hold_req = 0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (rx_gap > 0) begin
            m_ready <= 1'b0;
            rx_gap--;
        end else begin
            m_ready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
        end
    end

    // compare each output transaction with the oldest expected byte
    always @(posedge aclk) begin
        packed_result_t got;
        packed_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_packed_byte, m_run_end, m_stream_end};
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected output byte %h run_end %b stream_end %b",
                         $time, got.packed_byte, got.run_end, got.stream_end);
                error_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch, expected byte/run/stream %h/%b/%b, got %h/%b/%b",
                             $time, want.packed_byte, want.run_end, want.stream_end,
                             got.packed_byte, got.run_end, got.stream_end);
                    error_count++;
                end
                bytes_checked++;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress, %0d bytes still expected", $time, expected_bytes.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // test sequence
    initial begin
        restart_encoder();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_byte_streams();
        test_aligned_end();
        test_prefix_extension();
        test_random_streams();
        test_backpressure();
        test_sender_pause();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("covered %0d input bytes over %0d streams, %0d packed bytes checked",
                 bytes_sent, streams_done, bytes_checked);
        $display("code width reached %0d bits, %0d dictionary restarts at full width",
                 peak_width, full_clears);
        if (error_count == 0 && expected_bytes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/lzwbsc_pkg.sv
sv/lzw_byte_stream_compressor.sv
tb/tb.sv
